FILE: rtl/core/s2cd_pkg.sv
// Shared types and constants for the seconds to calendar date unit.
package s2cd_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned Days400y    = 146097;
    localparam int unsigned Days100y    = 36524;
    localparam int unsigned Days4y      = 1461;
    localparam int unsigned Days1y      = 365;
    localparam int unsigned BaseYear    = 2000;

    localparam logic [1:0] CfgZoneHours   = 2'd0;
    localparam logic [1:0] CfgZoneMinutes = 2'd1;
    localparam logic [1:0] CfgEpoch       = 2'd2;

    // datapath steps, one per controller state
    typedef struct packed {
        logic load;
        logic day_step;
        logic div_step;
        logic cyc_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cyc_done;
    } t_status;

    // month lengths from March, leap February last
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: month_len = 5'd31;
            4'd1, 4'd3, 4'd6, 4'd8:                    month_len = 5'd30;
            default:                                   month_len = 5'd29;
        endcase
    endfunction

endpackage

FILE: rtl/core/s2cd_ctrl.sv
// Controller state machine for the seconds to calendar date unit.
module s2cd_ctrl
    import s2cd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DAY  = 5'b00010,
        S_DIV  = 5'b00100,
        S_CYC  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DAY;
                end
            end
            S_DAY: begin
                o_cmd.day_step = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_CYC;
                end
            end
            S_CYC: begin
                o_cmd.cyc_step = 1'b1;
                if (i_status.cyc_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result dropped while stalled");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");

endmodule

FILE: rtl/core/s2cd_dpath.sv
// Datapath: zone shift, reciprocal divisions, cycle and month walk.
module s2cd_dpath
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_stamp,
    input  logic [4:0]  i_zone_hours,
    input  logic [5:0]  i_zone_minutes,
    input  logic [31:0] i_epoch,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds
);

    // reciprocals: q = (x * M) >> S, exact over each operand range
    localparam logic [25:0] RecipDay  = 26'd50903317;  // (secs >> 7) / 675, S = 35
    localparam logic [17:0] RecipHour = 18'd149131;    // tod / 3600, S = 29
    localparam logic [12:0] RecipMin  = 13'd4370;      // x < 3600, / 60, S = 18
    localparam logic [16:0] RecipWeek = 17'd74899;     // x < 2^16, / 7, S = 19

    // division steps 0..6, each a multiply, a subtract or both
    logic [31:0] r_secs;
    logic [2:0]  r_step;
    logic [50:0] r_prod;
    logic [15:0] r_days;
    logic [31:0] r_dsec;      // days * 86400
    logic [32:0] r_wprod;
    logic [16:0] r_tod;       // seconds of the day
    logic [34:0] r_hprod;
    logic [11:0] r_hsec;      // seconds within the hour
    logic [24:0] r_mprod;
    logic [4:0]  r_hours;
    logic [5:0]  r_minutes;
    logic [5:0]  r_seconds;
    logic [15:0] w_days;
    logic [15:0] w_wx;
    logic [13:0] w_wq;
    logic [4:0]  w_hr;
    logic [5:0]  w_mn;

    // cycle walk: phase 0..3 = 400y,100y,4y,1y(repeat subtract), 4 = months
    logic [2:0]  r_phase;
    logic [15:0] r_drem;
    logic [4:0]  r_cnt;
    logic [7:0]  r_years;
    logic [3:0]  r_mon;
    logic [2:0]  r_wd;
    logic [15:0] w_unit;
    logic [4:0]  w_cap;
    logic [6:0]  w_mul;
    logic [31:0] w_zone;
    logic signed [31:0] w_hrs;

    assign w_hrs  = 32'(signed'(i_zone_hours)) * 32'sd3600;
    assign w_zone = 32'(w_hrs) + 32'(i_zone_minutes) * 32'(SecsPerMin);

    assign w_days = r_prod[50:35];
    assign w_wx   = r_days + 16'd3;
    assign w_wq   = r_wprod[32:19];
    assign w_hr   = r_hprod[33:29];
    assign w_mn   = r_mprod[23:18];

    always_comb begin
        w_unit = 16'(Days1y);
        w_cap  = 5'd3;
        w_mul  = 7'd1;
        case (r_phase)
            3'd0: begin w_unit = 16'hFFFF; w_cap = 5'd0; w_mul = 7'd0; end
            3'd1: begin w_unit = 16'(Days100y); w_cap = 5'd3; w_mul = 7'd100; end
            3'd2: begin w_unit = 16'(Days4y); w_cap = 5'd24; w_mul = 7'd4; end
            default: ;
        endcase
    end

    assign o_status.div_done = (r_step == 3'd6);
    assign o_status.cyc_done = (r_phase == 3'd4) &&
        (r_mon == 4'd11 || r_drem < 16'(month_len(r_mon)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_secs <= i_stamp + w_zone;
        end
        if (i_cmd.day_step) begin
            r_secs <= r_secs - i_epoch;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_step  <= r_step + 3'd1;
            r_phase <= '0;
            case (r_step)
                3'd0: r_prod <= 51'(r_secs[31:7]) * 51'(RecipDay);
                3'd1: begin
                    r_days <= w_days;
                    r_dsec <= 32'(w_days) * 32'(SecsPerDay);
                end
                3'd2: begin
                    r_tod   <= 17'(r_secs - r_dsec);
                    r_wprod <= 33'(w_wx) * 33'(RecipWeek);
                end
                3'd3: begin
                    r_hprod <= 35'(r_tod) * 35'(RecipHour);
                    r_wd    <= 3'(w_wx - 16'(w_wq) * 16'd7);
                end
                3'd4: begin
                    r_hours <= w_hr;
                    r_hsec  <= 12'(r_tod - 17'(w_hr) * 17'(SecsPerHour));
                end
                3'd5: r_mprod <= 25'(r_hsec) * 25'(RecipMin);
                3'd6: begin
                    r_minutes <= w_mn;
                    r_seconds <= 6'(r_hsec - 12'(w_mn) * 12'd60);
                end
                default: ;
            endcase
        end
        if (i_cmd.cyc_step) begin
            if (r_phase == 3'd0) begin
                // days < 49711 < 146097, so no full 400-year cycle
                r_drem  <= r_days;
                r_cnt   <= '0;
                r_years <= '0;
                r_mon   <= '0;
                r_phase <= 3'd1;
            end else if (r_phase == 3'd4) begin
                if (!o_status.cyc_done) begin
                    r_drem <= r_drem - 16'(month_len(r_mon));
                    r_mon  <= r_mon + 4'd1;
                end
            end else if (r_drem >= w_unit && r_cnt != w_cap) begin
                r_drem  <= r_drem - w_unit;
                r_cnt   <= r_cnt + 5'd1;
                r_years <= r_years + 8'(w_mul);
            end else begin
                r_cnt   <= '0;
                r_phase <= r_phase + 3'd1;
            end
        end
        if (i_cmd.finish) begin
            o_year    <= 12'(BaseYear) + 12'(r_years) + ((r_mon >= 4'd10) ? 12'd1 : 12'd0);
            o_month   <= (r_mon >= 4'd10) ? r_mon - 4'd9 : r_mon + 4'd3;
            o_day     <= 5'(r_drem) + 5'd1;
            o_weekday <= r_wd;
            o_hours   <= r_hours;
            o_minutes <= r_minutes;
            o_seconds <= r_seconds;
        end
    end

endmodule

FILE: rtl/core/seconds_to_calendar_date_unit.sv
// Top level of the seconds to calendar date unit.
// From the accepting edge to valid: the epoch subtract, 7 reciprocal divide steps, the
// cycle walk (century, four-year, year and month subtracts), then the output state.
// The four-year subtract walk sets most of the spread. A new word is taken only in idle,
// after the last has reached the result register, which frees input while it waits; a
// result still untaken when the next walk ends stalls that word in its output state.
// Reset (synchronous, active low): zone 0h 0m, epoch 3160857600, no result.
module seconds_to_calendar_date_unit
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_stamp_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds
);

    logic [4:0]  r_zone_hours;
    logic [5:0]  r_zone_minutes;
    logic [31:0] r_epoch;
    t_cmd        w_cmd;
    t_status     w_status;

    // config registers; index 3 is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_hours   <= '0;
            r_zone_minutes <= '0;
            r_epoch        <= 32'd3160857600;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgZoneHours:   r_zone_hours   <= i_cfg_data[4:0];
                CfgZoneMinutes: r_zone_minutes <= i_cfg_data[5:0];
                CfgEpoch:       r_epoch        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    s2cd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    s2cd_dpath u_dpath (
        .i_clk          (i_clk),
        .i_stamp        (i_stamp_seconds),
        .i_zone_hours   (r_zone_hours),
        .i_zone_minutes (r_zone_minutes),
        .i_epoch        (r_epoch),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day_of_month),
        .o_weekday      (o_weekday),
        .o_hours        (o_hours),
        .o_minutes      (o_minutes),
        .o_seconds      (o_seconds)
    );

endmodule

FILE: tb/sv/seconds_to_calendar_date_checker.sv
// Checker for the seconds to calendar date unit: predicts each date and compares.
module seconds_to_calendar_date_checker
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_stamp_seconds,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_hours,
    input  logic [5:0]  i_minutes,
    input  logic [5:0]  i_seconds,
    output int          o_errors,
    output int          o_pending,
    output int          o_dates_seen
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_date;

    logic signed [4:0] zone_h;
    logic [5:0]        zone_m;
    logic [31:0]       epoch;
    t_date             dates_due[$];

    // Gregorian split of the shifted stamp, March-first years
    function automatic t_date calendar_of(input logic [31:0] stamp);
        logic [31:0] secs, days, tod, rem, c400, c100, c4, c1, years, mon;
        logic [4:0]  mlen;
        t_date d;
        secs = stamp + 32'($signed(zone_h) * 3600) + 32'(zone_m) * 32'd60 - epoch;
        days = secs / 86400;
        tod  = secs % 86400;
        c400 = days / 146097;
        rem  = days % 146097;
        c100 = rem / 36524;
        if (c100 == 4) c100 = 3;
        rem -= c100 * 36524;
        c4 = rem / 1461;
        if (c4 == 25) c4 = 24;
        rem -= c4 * 1461;
        c1 = rem / 365;
        if (c1 == 4) c1 = 3;
        rem -= c1 * 365;
        years = c1 + 4 * c4 + 100 * c100 + 400 * c400;
        mon = 0;
        for (int i = 0; i < 11; i++) begin
            case (i)
                1, 3, 6, 8: mlen = 5'd30;
                default:    mlen = 5'd31;
            endcase
            if (rem < mlen) break;
            rem -= mlen;
            mon++;
        end
        mon += 3;
        if (mon > 12) begin
            mon -= 12;
            years++;
        end
        d.year    = 12'(years + 2000);
        d.month   = 4'(mon);
        d.mday    = 5'(rem + 1);
        d.wday    = 3'(((days % 7) + 3) % 7);
        d.hours   = 5'(tod / 3600);
        d.minutes = 6'((tod / 60) % 60);
        d.seconds = 6'(tod % 60);
        return d;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_dates_seen = 0;
    end

    assign o_pending = dates_due.size();

    always @(posedge i_clk) begin
        t_date want;
        if (!i_rst_n) begin
            zone_h <= '0;
            zone_m <= '0;
            epoch  <= 32'd3160857600;
        end else begin
            if (i_in_valid && i_in_ready) dates_due.push_back(calendar_of(i_stamp_seconds));
            if (i_out_valid && i_out_ready) begin
                o_dates_seen++;
                if (dates_due.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    want = dates_due.pop_front();
                    if (i_year != want.year)         report("year", i_year, want.year);
                    if (i_month != want.month)       report("month", i_month, want.month);
                    if (i_day_of_month != want.mday) report("day", i_day_of_month, want.mday);
                    if (i_weekday != want.wday)      report("weekday", i_weekday, want.wday);
                    if (i_hours != want.hours)       report("hours", i_hours, want.hours);
                    if (i_minutes != want.minutes)   report("minutes", i_minutes, want.minutes);
                    if (i_seconds != want.seconds)   report("seconds", i_seconds, want.seconds);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgZoneHours:   zone_h <= i_cfg_data[4:0];
                    CfgZoneMinutes: zone_m <= i_cfg_data[5:0];
                    CfgEpoch:       epoch  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: tb/sv/seconds_to_calendar_date_unit_test.sv
// Testbench top: stimulus, configuration phases and verdict for the date unit.
module seconds_to_calendar_date_unit_test
    import s2cd_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid, in_ready;
    logic [31:0] stamp;
    logic        out_valid, out_ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday, hours;
    logic [2:0]  wday;
    logic [5:0]  minutes, seconds;
    int          errors, pending, dates_seen;
    int          cycles;
    int          words_sent;
    bit          drain_done;

    seconds_to_calendar_date_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_stamp_seconds(stamp),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_year(year), .o_month(month), .o_day_of_month(mday), .o_weekday(wday),
        .o_hours(hours), .o_minutes(minutes), .o_seconds(seconds)
    );

    seconds_to_calendar_date_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_stamp_seconds(stamp),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_year(year), .i_month(month), .i_day_of_month(mday), .i_weekday(wday),
        .i_hours(hours), .i_minutes(minutes), .i_seconds(seconds),
        .o_errors(errors), .o_pending(pending), .o_dates_seen(dates_seen)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gap length: most often none, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    // watchdog: the worst case per word plus long stalls, many times over
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sink: random backpressure, with quiet stretches of always-ready
    initial begin
        int hold;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 200 : 1;
            repeat (hold) begin
                @(posedge clk);
                out_ready <= (hold > 1) || (gap_len() == 0);
            end
        end
    end

    // one word; valid stays up until taken, then a random gap
    task automatic send_word(input logic [31:0] s);
        int g;
        in_valid <= 1'b1;
        stamp    <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // let every expected date come back, then the unit's full latency for safety
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // write enable stays up across a burst; the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_zone(input logic [4:0] h, input logic [5:0] m, input logic [31:0] e);
        write_reg(CfgZoneHours, {27'd0, h});
        write_reg(CfgZoneMinutes, {26'd0, m});
        write_reg(CfgEpoch, e);
        cfg_we <= 1'b0;
    endtask

    // stamps within 400 days after the epoch instant, around raw midnights, near the top of the range, or random
    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 3))
            0: return 32'd3160857600 + $urandom_range(0, 86400 * 400);
            1: return $urandom_range(0, 2) * 32'd86400 + $urandom_range(86395, 86405)
                      + 32'd86400 * $urandom_range(0, 49000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] corner[$];
        int phase;
        cycles = 0;
        words_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CfgZoneHours;
        cfg_data = '0;
        in_valid = 1'b0;
        stamp = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, epoch instant, leap days, century edges, wrap
        corner = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'd3160857600, 32'd3160857599,
                   32'd3160857600 + 32'd86400 * 365 - 1,
                   32'd3160857600 + 32'd86400 * 1460,
                   32'd3160857600 + 32'd86400 * 1461 - 1,
                   32'd3160857600 + 32'd86400 * 36524,
                   32'd3160857600 + 32'd86400 * 36523,
                   32'd3160857600 + 32'd86400 * 146096,
                   32'd3160857600 + 32'd86400 * 146097,
                   32'd3160857600 + 32'd86400 * 306 + 86399,
                   32'd3160857600 + 32'd86400 * 335};
        foreach (corner[i]) send_word(corner[i]);
        drain();

        // zone extremes, including out-of-range codes the register still takes
        set_zone(5'b10000, 6'd63, 32'd0);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'd57600);
        drain();
        set_zone(5'b01111, 6'd0, 32'hFFFF_FFFF);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        drain();

        // random phases, each under a fresh zone setting
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_zone(5'd0, 6'd0, 32'd3160857600);
                1: set_zone(5'b10100, 6'd0, 32'd3160857600);  // -12 h
                2: set_zone(5'd14, 6'd59, 32'd3160857600);
                default: set_zone(5'($urandom()), 6'($urandom()),
                                  ($urandom_range(0, 1) != 0) ? 32'd3160857600 : $urandom());
            endcase
            repeat (110) send_word(pick_stamp());
            drain();
        end

        $display("covered %0d words over directed edges and 8 zone/epoch settings", words_sent);
        $display("dates checked: %0d, mismatches: %0d", dates_seen, errors);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
